### sv/crni_pkg.sv
// Shared types, constants and the binomial table builder for the
// combination rank node index core. No dependencies.
package crni_pkg;

  localparam int MAX_VARS_DEF    = 8;
  localparam int NODE_STRIDE_DEF = 1;

  localparam int LEVEL_W  = 4;
  localparam int POS_W    = 8;
  localparam int SIDE_W   = 8;
  localparam int IDX_W    = 32;
  localparam int POS_FIELDS = 8;
  localparam int POS_DEPTH  = 1 << POS_W;
  localparam int BINOM_K_MAX = 8;

  localparam int IN_DATA_BITS = LEVEL_W + POS_FIELDS * POS_W + SIDE_W;
  localparam int IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W   = IDX_W;

  typedef logic [POS_DEPTH-1:0][IDX_W-1:0] binom_row_t;

  // Control fields that travel alongside the lane terms.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SIDE_W-1:0]  side;
  } crni_ctl_t;

  // Entry p holds C(p - 1, k) modulo 2^32, and zero where p - 1 < k.
  // Built by Pascal's rule, so only additions are needed.
  function automatic binom_row_t binom_row(input int k);
    logic [IDX_W-1:0] col [BINOM_K_MAX+1];
    binom_row_t row;
    for (int j = 0; j <= BINOM_K_MAX; j++) begin
      col[j] = '0;
    end
    col[0] = IDX_W'(1);
    row[0] = '0;
    for (int p = 1; p < POS_DEPTH; p++) begin
      row[p] = col[k];
      for (int j = BINOM_K_MAX; j >= 1; j--) begin
        col[j] = col[j] + col[j-1];
      end
    end
    return row;
  endfunction

endpackage

### sv/crni_lane.sv
// One rank lane: looks up C(pos - 1, LANE + 1) in a constant table and
// zeroes the term when the lane lies at or past the node level. Uses crni_pkg.
module crni_lane
  import crni_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic [POS_W-1:0]   pos,
  input  logic [LEVEL_W-1:0] level_sat,
  output logic [IDX_W-1:0]   term
);

  localparam binom_row_t TBL = binom_row(LANE + 1);

  logic active;

  assign active = level_sat > LEVEL_W'(LANE);
  assign term   = active ? TBL[pos] : '0;

endmodule

### sv/crni_merge.sv
// Merging pipeline: sums the lane terms in two steps, applies the level
// shift and side bits, then scales by the node stride. Uses crni_pkg.
module crni_merge
  import crni_pkg::*;
#(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int NODE_STRIDE = NODE_STRIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  output logic                           s1_ready,
  input  crni_ctl_t                      s1_ctl,
  input  logic [MAX_VARS-1:0][IDX_W-1:0] s1_terms,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic [IDX_W-1:0]               m_index
);

  localparam int STRIDE_W = $clog2(NODE_STRIDE + 1);
  localparam logic [STRIDE_W-1:0] STRIDE = STRIDE_W'(NODE_STRIDE);

  logic             s2_valid_r, s2_valid_nxt;
  logic             s3_valid_r, s3_valid_nxt;
  logic             s4_valid_r, s4_valid_nxt;
  logic             s2_ready, s3_ready, s4_ready;
  crni_ctl_t        s2_ctl_r;
  logic [IDX_W-1:0] s2_even_r, s2_odd_r;
  logic [IDX_W-1:0] even_sum, odd_sum;
  logic [IDX_W-1:0] s3_value_r, s3_value;
  logic [IDX_W-1:0] s4_index_r;
  logic [IDX_W+STRIDE_W-1:0] product;

  // A stage takes a new request when it is empty or its content moves on.
  assign s4_ready = !s4_valid_r || m_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = s2_ready;

  always_comb begin
    even_sum = '0;
    odd_sum  = '0;
    for (int i = 0; i < MAX_VARS; i++) begin
      if (i % 2 == 0) begin
        even_sum = even_sum + s1_terms[i];
      end else begin
        odd_sum = odd_sum + s1_terms[i];
      end
    end
  end

  assign s3_value = ((s2_even_r + s2_odd_r) << s2_ctl_r.level)
                    + IDX_W'(s2_ctl_r.side);
  assign product  = s3_value_r * STRIDE;

  assign s2_valid_nxt = s2_ready ? s1_valid   : s2_valid_r;
  assign s3_valid_nxt = s3_ready ? s2_valid_r : s3_valid_r;
  assign s4_valid_nxt = s4_ready ? s3_valid_r : s4_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_ctl_r  <= s1_ctl;
      s2_even_r <= even_sum;
      s2_odd_r  <= odd_sum;
    end
    if (s3_ready && s2_valid_r) begin
      s3_value_r <= s3_value;
    end
    if (s4_ready && s3_valid_r) begin
      s4_index_r <= product[IDX_W-1:0];
    end
  end

  assign m_valid = s4_valid_r;
  assign m_index = s4_index_r;

endmodule

### sv/combination_rank_node_index_core.sv
// Top level of the combination rank node index core: input register stage,
// one table lane per variable position and the merging pipeline.
// Depends on crni_pkg, crni_lane and crni_merge.
//
//  Channel | Ports      | tdata fields, lowest bit up
//  --------+------------+-----------------------------------------------------
//  input   | in_t*      | level[3:0], pos_0..pos_7 [11:4]..[67:60], side_bits
//          |            | [75:68], zero fill to 80 bits
//  result  | out_t*     | node_index[31:0]
//
// One request is accepted every cycle while the output is not stalled; the lane
// table lookup, two-way partial sums, shift and add, and the stride multiply
// each end in a register, in that order. Reset clears only the stage
// valid flags. Each stage holds while the one after it is full and stalled,
// and empty stages keep taking requests while a result waits at the output.
module combination_rank_node_index_core
  import crni_pkg::*;
#(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int NODE_STRIDE = NODE_STRIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // level, pos_0 .. pos_7, side_bits, from the lowest bit up
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // node_index
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_VARS);
  localparam int SIDE_LSB = LEVEL_W + POS_FIELDS * POS_W;

  logic [LEVEL_W-1:0]           in_level, level_sat;
  logic [SIDE_W-1:0]            in_side;
  logic [MAX_VARS-1:0][IDX_W-1:0] lane_terms;
  logic [MAX_VARS-1:0][IDX_W-1:0] s1_terms_r;
  crni_ctl_t                    s1_ctl_r;
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_ready, merge_ready;

  assign in_level  = in_tdata[LEVEL_W-1:0];
  assign in_side   = in_tdata[SIDE_LSB +: SIDE_W];
  assign level_sat = (in_level > LEVEL_MAX) ? LEVEL_MAX : in_level;

  for (genvar g = 0; g < MAX_VARS; g++) begin : g_lane
    crni_lane #(
      .LANE (g)
    ) u_lane (
      .pos       (in_tdata[LEVEL_W + g * POS_W +: POS_W]),
      .level_sat (level_sat),
      .term      (lane_terms[g])
    );
  end

  assign s1_ready     = !s1_valid_r || merge_ready;
  assign in_tready    = s1_ready;
  assign s1_valid_nxt = s1_ready ? in_tvalid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_terms_r     <= lane_terms;
      s1_ctl_r.level <= level_sat;
      s1_ctl_r.side  <= in_side;
    end
  end

  crni_merge #(
    .MAX_VARS    (MAX_VARS),
    .NODE_STRIDE (NODE_STRIDE)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_ready (merge_ready),
    .s1_ctl   (s1_ctl_r),
    .s1_terms (s1_terms_r),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_index  (out_tdata)
  );

endmodule
